[hw/rtl/csw_pkg.sv]
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types and constants for the counting semaphore with a wait queue.
// ----------------------------------------------------------------------------
package csw_pkg;

    localparam int unsigned TID_W   = 8;
    localparam int unsigned CFG_W   = 15;
    localparam int unsigned COUNT_W = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

    typedef enum logic [1:0] {
        OP_WAIT   = 2'd0,
        OP_SIGNAL = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_TRY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BLOCKED  = 2'd1,
        ST_CLOSED   = 2'd2,
        ST_CAPACITY = 2'd3
    } t_status;

    // Request beat as it arrives on the input side
    typedef struct packed {
        logic [1:0]       op;
        logic [TID_W-1:0] thread_id;
    } t_in_item;

    // Result beat as it leaves on the output side
    typedef struct packed {
        logic [1:0]       status;
        logic             woken_valid;
        logic [TID_W-1:0] woken_thread;
        logic             woken_by_close;
        logic             available;
        logic             last;
    } t_out_item;

    // Decoded command passed from front to back
    typedef struct packed {
        t_op              op;
        logic [TID_W-1:0] tid;
    } t_cmd;

endpackage

[hw/rtl/csw_front.sv]
// ----------------------------------------------------------------------------
// csw_front
// Accepts request beats, decodes them into commands and holds them in a
// two-entry command queue for the execution side.
// ----------------------------------------------------------------------------
module csw_front #(
    parameter int unsigned TW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csw_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output csw_pkg::t_cmd     o_cmd
);
    import csw_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       w_push_ok;
    logic       w_take_ok;
    t_cmd       w_cmd;

    // Decode the beat: cast the op, keep the low thread id bits
    always_comb begin
        w_cmd.op  = t_op'(i_item.op);
        w_cmd.tid = TID_W'(i_item.thread_id[TW-1:0]);
    end

    assign o_full      = (r_fill == 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_push_ok   = i_push && !o_full;
    assign w_take_ok   = i_cmd_take && o_cmd_valid;

    // Store decoded commands
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_take_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push_ok, w_take_ok})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

[hw/rtl/csw_result_queue.sv]
// ----------------------------------------------------------------------------
// csw_result_queue
// Two-entry result queue that parts the execution side from the receiver.
// ----------------------------------------------------------------------------
module csw_result_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  csw_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output csw_pkg::t_out_item o_item
);
    import csw_pkg::*;

    t_out_item  r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       w_push_ok;
    logic       w_pop_ok;

    assign o_full    = (r_fill == 2'd2);
    assign o_empty   = (r_fill == 2'd0);
    assign o_item    = r_slot[r_rd_ptr];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    // Store result beats
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

[hw/rtl/csw_back.sv]
// ----------------------------------------------------------------------------
// csw_back
// Executes commands against the semaphore state: signed count, closed flag
// and the FIFO of blocked thread ids. A close drains one waiter per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module csw_back #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TW          = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [csw_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_cmd_valid,
    input  csw_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_take,
    input  logic                      i_res_full,
    output logic                      o_res_push,
    output csw_pkg::t_out_item        o_res
);
    import csw_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } t_state;

    t_state                    r_state, n_state;
    t_cmd                      r_cmd;
    logic signed [COUNT_W-1:0] r_count, n_count;
    logic                      r_closed, n_closed;
    logic [AW-1:0]             r_head, n_head;
    logic [AW-1:0]             r_tail, n_tail;
    logic [FW-1:0]             r_fill, n_fill;
    logic [TW-1:0]             r_wait_mem [QUEUE_DEPTH];
    logic [TW-1:0]             r_rd_data;
    logic                      w_we;
    t_out_item                 w_res;

    // Sequence one command at a time and build its result beats
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_closed   = r_closed;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        w_we       = 1'b0;
        o_res_push = 1'b0;
        o_cmd_take = 1'b0;
        w_res      = '{status: ST_OK, last: 1'b1, default: '0};

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                    if (r_closed) begin
                        o_res_push = 1'b1;
                        w_res.status = ST_CLOSED;
                    end else begin
                        case (r_cmd.op)
                            OP_WAIT: begin
                                o_res_push = 1'b1;
                                if (r_count <= 16'sd0) begin
                                    if (r_fill == FULL_FILL) begin
                                        w_res.status = ST_CAPACITY;
                                    end else begin
                                        n_count = r_count - 16'sd1;
                                        w_we    = 1'b1;
                                        n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                                        n_fill  = r_fill + 1'b1;
                                        w_res.status = ST_BLOCKED;
                                    end
                                end else begin
                                    n_count = r_count - 16'sd1;
                                end
                            end
                            OP_SIGNAL: begin
                                o_res_push = 1'b1;
                                if (r_count == COUNT_MAX) begin
                                    w_res.status = ST_CAPACITY;
                                end else begin
                                    n_count = r_count + 16'sd1;
                                    if (r_count < 16'sd0 && r_fill != '0) begin
                                        n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                                        n_fill = r_fill - 1'b1;
                                        w_res.woken_valid  = 1'b1;
                                        w_res.woken_thread = TID_W'(r_rd_data);
                                    end
                                end
                            end
                            OP_CLOSE: begin
                                n_closed = 1'b1;
                                if (r_fill == '0) begin
                                    o_res_push = 1'b1;
                                end else begin
                                    n_state = S_DRAIN;
                                end
                            end
                            default: begin
                                o_res_push = 1'b1;
                                w_res.available = (r_count > 16'sd0);
                            end
                        endcase
                    end
                end
            end
            S_DRAIN: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    w_res.woken_valid    = 1'b1;
                    w_res.woken_thread   = TID_W'(r_rd_data);
                    w_res.woken_by_close = 1'b1;
                    w_res.last           = (r_fill == FW'(1));
                    n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    n_fill = r_fill - 1'b1;
                    if (r_fill == FW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = w_res;

    // Hold state, reload it on a configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_closed <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
        end else if (i_cfg_we) begin
            r_state  <= S_IDLE;
            r_count  <= signed'({1'b0, i_cfg_data});
            r_closed <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_closed <= n_closed;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
        end
    end

    // Latch the command being executed
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
    end

    // Waiter memory: one write port, registered read at the next head
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wait_mem[r_tail] <= r_cmd.tid[TW-1:0];
        end
        r_rd_data <= r_wait_mem[n_head];
    end

endmodule

[hw/rtl/counting_semaphore_wait_queue.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO of blocked thread ids.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as a queue push: a beat of {op, thread_id} is taken at a
//   clock edge with push high and full low. Results leave as a queue: the
//   oldest result sits on o_result while empty is low and is taken at an
//   edge with pop high and empty low.
//   Every request gives one result beat; a close with waiters gives one beat
//   per waiter, the final one marked by last.
//   The execution sequencer handles one request at a time: it takes a
//   command, then executes it against the waiter memory, and it takes no
//   new request before it is through with the last one; a close drains
//   one waiter per cycle after that while the result queue has room.
//   A two-entry command queue and a two-entry result queue let the input
//   keep filling while the receiver stalls; execution pauses when the
//   result queue is full and the input shows full once commands back up.
//   Reset clears both queues, sets the count to 0 and opens the semaphore.
//   A write on i_cfg_we loads the count from i_cfg_data, reopens the
//   semaphore and empties the wait queue; write only while the block is idle.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue #(
    parameter int unsigned QUEUE_DEPTH    = 16,
    parameter int unsigned THREAD_ID_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    input  csw_pkg::t_in_item         i_item,
    output logic                      full,
    output logic                      empty,
    input  logic                      pop,
    output csw_pkg::t_out_item        o_result,
    input  logic                      i_cfg_we,
    input  logic [csw_pkg::CFG_W-1:0] i_cfg_data
);
    import csw_pkg::*;

    localparam int unsigned TW = (THREAD_ID_BITS < TID_W) ? THREAD_ID_BITS : TID_W;

    logic      w_cmd_valid;
    logic      w_cmd_take;
    t_cmd      w_cmd;
    logic      w_res_full;
    logic      w_res_push;
    t_out_item w_res;

    // Front: accept and decode requests
    csw_front #(
        .TW (TW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_take  (w_cmd_take),
        .o_cmd       (w_cmd)
    );

    // Back: execute against semaphore state
    csw_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TW          (TW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Result queue toward the receiver
    csw_result_queue u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_item  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_result)
    );

endmodule

[hw/rtl/csw_checker.sv]
// ----------------------------------------------------------------------------
// csw_checker
// Port-level checks on the result channel of the semaphore block.
// ----------------------------------------------------------------------------
module csw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input csw_pkg::t_out_item o_result
);
    import csw_pkg::*;

    // Hold a waiting result beat until it is popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result beat changed while stalled");

    // Come out of reset with no results
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Release threads only with an ok status
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.woken_valid) |-> (o_result.status == ST_OK))
        else $error("wakeup carries an error status");

    // Tie a close wakeup to a released thread
    a_close_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.woken_by_close) |-> o_result.woken_valid)
        else $error("close wakeup without a released thread");

    // Report availability only on a plain ok result
    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.available) |->
            (o_result.status == ST_OK && !o_result.woken_valid && o_result.last))
        else $error("availability on a wrong result");

endmodule

bind counting_semaphore_wait_queue csw_checker u_csw_checker (.*);
